[rtl/order_book_level_table_assert.svh]
// Assertion macros for the order book level table checker.
// Used by obl_checker.sv; no other dependencies.
`ifndef ORDER_BOOK_LEVEL_TABLE_ASSERT_SVH
`define ORDER_BOOK_LEVEL_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define OBL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("order book level table: assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define OBL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("order book level table: assertion failed");

`endif

[rtl/obl_pkg.sv]
// Shared types, widths and codes for the order book level table.
// No dependencies.
package obl_pkg;

  localparam int MAX_LEVELS  = 16;
  localparam int INIT_LEVELS = 10;

  localparam int CNT_W  = $clog2(MAX_LEVELS + 1);
  localparam int LVL_W  = 4;
  localparam int FUNC_W = 3;
  localparam int VAL_W  = 31;
  localparam int ST_W   = 2;
  localparam int TP_W   = VAL_W + 4;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int REG_W  = ADDR_W - 2;

  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_LEVELS);
  localparam logic [CNT_W-1:0] CNT_INIT =
    CNT_W'((INIT_LEVELS > MAX_LEVELS) ? MAX_LEVELS : INIT_LEVELS);

  localparam logic [FUNC_W-1:0] FN_UPDATE = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CHECK  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  localparam logic [REG_W-1:0] REG_INIT_PRICE = '0;
  localparam logic [VAL_W-1:0] INIT_PRICE_RST = 31'd1;

  typedef struct packed {
    logic [VAL_W-1:0] price;
    logic [VAL_W-1:0] volume;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } obl_cmd_t;

endpackage

[rtl/obl_ctrl.sv]
// Controller for the order book level table: sequences capture and execute,
// owns the input and result handshakes. Depends on obl_pkg.
module obl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output obl_pkg::obl_cmd_t cmd
);
  import obl_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          cmd.execute   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/obl_datapath.sv]
// Datapath for the order book level table: both level tables, counts,
// price band register, request capture and result registers. Depends on obl_pkg.
module obl_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  obl_pkg::obl_cmd_t          cmd,
  input  logic [obl_pkg::FUNC_W-1:0] in_func,
  input  logic                       in_side,
  input  logic [obl_pkg::LVL_W-1:0]  in_level,
  input  logic [obl_pkg::VAL_W-1:0]  in_price,
  input  logic [obl_pkg::VAL_W-1:0]  in_volume,
  input  logic                       cfg_we,
  input  logic [obl_pkg::VAL_W-1:0]  cfg_wdata,
  output logic [obl_pkg::VAL_W-1:0]  init_price,
  output logic [obl_pkg::VAL_W-1:0]  out_price,
  output logic [obl_pkg::VAL_W-1:0]  out_volume,
  output logic [obl_pkg::ST_W-1:0]   out_status,
  output logic                       out_price_ok,
  output logic [obl_pkg::CNT_W-1:0]  out_level_count
);
  import obl_pkg::*;

  entry_t           ask_r [MAX_LEVELS];
  entry_t           bid_r [MAX_LEVELS];
  logic [CNT_W-1:0] ask_cnt_r, bid_cnt_r;
  logic [VAL_W-1:0] init_price_r;

  logic [FUNC_W-1:0] func_r;
  logic              side_r;
  logic [LVL_W-1:0]  lvl_r;
  logic [VAL_W-1:0]  price_r;
  logic [VAL_W-1:0]  vol_r;
  logic [TP_W-1:0]   tp_r;

  logic [VAL_W-1:0] res_price_r, res_volume_r;
  logic [ST_W-1:0]  res_status_r;
  logic             res_ok_r;
  logic [CNT_W-1:0] res_cnt_r;

  entry_t           sel_tab    [MAX_LEVELS];
  entry_t           from_above [MAX_LEVELS];
  entry_t           from_below [MAX_LEVELS];
  entry_t           tab_nxt    [MAX_LEVELS];
  logic [CNT_W-1:0] cnt_nxt;
  logic [VAL_W-1:0] rd_price, rd_volume;
  logic [ST_W-1:0]  st_nxt;
  logic             ok_nxt;
  logic [TP_W-1:0]  band_lo, band_hi;

  always_comb begin
    for (int i = 0; i < MAX_LEVELS; i++) begin
      sel_tab[i] = side_r ? bid_r[i] : ask_r[i];
    end
  end

  for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_nbr
    if (g == 0) begin : g_first
      assign from_above[g] = '0;
    end else begin : g_rest
      assign from_above[g] = sel_tab[g-1];
    end
    if (g == MAX_LEVELS - 1) begin : g_last
      assign from_below[g] = '0;
    end else begin : g_inner
      assign from_below[g] = sel_tab[g+1];
    end
  end

  assign band_lo = TP_W'({init_price_r, 3'b000}) - TP_W'(init_price_r);
  assign band_hi = TP_W'({init_price_r, 3'b000}) + TP_W'({init_price_r, 2'b00})
                 + TP_W'(init_price_r);

  always_comb begin
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] l;
    logic [CNT_W-1:0] top;
    logic [CNT_W-1:0] ii;
    logic             ins_ok;
    entry_t           new_e;
    n         = side_r ? bid_cnt_r : ask_cnt_r;
    l         = CNT_W'(lvl_r);
    new_e     = '{price: price_r, volume: vol_r};
    ins_ok    = (l <= n) && (l < CNT_MAX);
    top       = (n == CNT_MAX) ? (CNT_MAX - CNT_W'(1)) : n;
    cnt_nxt   = n;
    st_nxt    = ST_OK;
    ok_nxt    = 1'b0;
    rd_price  = '0;
    rd_volume = '0;
    case (func_r)
      FN_UPDATE: begin
        if (l >= n) begin
          if (n < CNT_MAX) begin
            cnt_nxt = n + CNT_W'(1);
          end else begin
            st_nxt = ST_FULL;
          end
        end
      end
      FN_INSERT: begin
        if (!ins_ok) begin
          st_nxt = ST_RANGE;
        end else if (n == CNT_MAX) begin
          st_nxt = ST_FULL;
        end else begin
          cnt_nxt = n + CNT_W'(1);
        end
      end
      FN_DELETE: begin
        if (l < n) begin
          cnt_nxt = n - CNT_W'(1);
        end else begin
          st_nxt = ST_RANGE;
        end
      end
      FN_READ: begin
        if (l < n) begin
          rd_price  = sel_tab[lvl_r].price;
          rd_volume = sel_tab[lvl_r].volume;
        end else begin
          st_nxt = ST_RANGE;
        end
      end
      FN_CHECK: ok_nxt = (tp_r >= band_lo) && (tp_r <= band_hi);
      default: ;
    endcase
    for (int i = 0; i < MAX_LEVELS; i++) begin
      ii         = CNT_W'(i);
      tab_nxt[i] = sel_tab[i];
      case (func_r)
        FN_UPDATE: begin
          if ((l < n && ii == l) || (l >= n && n < CNT_MAX && ii == n)) begin
            tab_nxt[i] = new_e;
          end
        end
        FN_INSERT: begin
          if (ins_ok) begin
            if (ii == l) begin
              tab_nxt[i] = new_e;
            end else if (ii > l && ii <= top) begin
              tab_nxt[i] = from_above[i];
            end
          end
        end
        FN_DELETE: begin
          if (l < n) begin
            if (ii >= l && (ii + CNT_W'(1)) < n) begin
              tab_nxt[i] = from_below[i];
            end else if (ii == n - CNT_W'(1)) begin
              tab_nxt[i] = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        ask_r[i] <= '0;
        bid_r[i] <= '0;
      end
      ask_cnt_r    <= CNT_INIT;
      bid_cnt_r    <= CNT_INIT;
      init_price_r <= INIT_PRICE_RST;
    end else begin
      if (cfg_we) begin
        init_price_r <= cfg_wdata;
      end
      if (cmd.execute) begin
        if (side_r) begin
          for (int i = 0; i < MAX_LEVELS; i++) begin
            bid_r[i] <= tab_nxt[i];
          end
          bid_cnt_r <= cnt_nxt;
        end else begin
          for (int i = 0; i < MAX_LEVELS; i++) begin
            ask_r[i] <= tab_nxt[i];
          end
          ask_cnt_r <= cnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= in_func;
      side_r  <= in_side;
      lvl_r   <= in_level;
      price_r <= in_price;
      vol_r   <= in_volume;
      tp_r    <= TP_W'({in_price, 3'b000}) + TP_W'({in_price, 1'b0});
    end
    if (cmd.execute) begin
      res_price_r  <= rd_price;
      res_volume_r <= rd_volume;
      res_status_r <= st_nxt;
      res_ok_r     <= ok_nxt;
      res_cnt_r    <= cnt_nxt;
    end
  end

  assign init_price      = init_price_r;
  assign out_price       = res_price_r;
  assign out_volume      = res_volume_r;
  assign out_status      = res_status_r;
  assign out_price_ok    = res_ok_r;
  assign out_level_count = res_cnt_r;

endmodule

[rtl/order_book_level_table.sv]
// Order book level table, top level: controller, datapath and register port.
// Depends on obl_pkg, obl_ctrl and obl_datapath.
//
// Keeps an ask and a bid table of price levels (price, volume, count in use).
// Input channel in_*: one request per transaction (func, side, level, price,
// volume). Result channel out_*: one result transaction per request, in order.
// Register port (psel/penable/pwrite/paddr/pwdata/prdata/pready): register 0
// at byte address 0 is the band center price of the 70..130% price band.
// Steps: the controller takes a request in a capture step, then registers its
// result in an execute step, and accepts no new request until that step is done;
// the tables shift all levels in parallel in the execute step.
// The result register decouples the channels: a new request is accepted while
// the previous result still waits. When out_stall holds the result, the
// execute step of the next request waits and in_stall stays high.
// Reset: both tables clear to zero, both counts start at INIT_LEVELS,
// the band center price returns to 1, and no result is pending.
module order_book_level_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [obl_pkg::FUNC_W-1:0] in_func,
  input  logic                       in_side,
  input  logic [obl_pkg::LVL_W-1:0]  in_level,
  input  logic [obl_pkg::VAL_W-1:0]  in_price,
  input  logic [obl_pkg::VAL_W-1:0]  in_volume,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [obl_pkg::VAL_W-1:0]  out_price,
  output logic [obl_pkg::VAL_W-1:0]  out_volume,
  output logic [obl_pkg::ST_W-1:0]   out_status,
  output logic                       out_price_ok,
  output logic [obl_pkg::CNT_W-1:0]  out_level_count,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [obl_pkg::ADDR_W-1:0] paddr,
  input  logic [obl_pkg::DATA_W-1:0] pwdata,
  output logic [obl_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import obl_pkg::*;

  obl_cmd_t         cmd;
  logic             reg_hit;
  logic             cfg_we;
  logic [VAL_W-1:0] init_price;

  assign reg_hit = (paddr[ADDR_W-1:2] == REG_INIT_PRICE);
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? DATA_W'(init_price) : '0;

  obl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  obl_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_func         (in_func),
    .in_side         (in_side),
    .in_level        (in_level),
    .in_price        (in_price),
    .in_volume       (in_volume),
    .cfg_we          (cfg_we),
    .cfg_wdata       (pwdata[VAL_W-1:0]),
    .init_price      (init_price),
    .out_price       (out_price),
    .out_volume      (out_volume),
    .out_status      (out_status),
    .out_price_ok    (out_price_ok),
    .out_level_count (out_level_count)
  );

endmodule

[rtl/obl_checker.sv]
// Port-level checker for the order book level table, bound to the top level.
// Depends on obl_pkg and order_book_level_table_assert.svh.
`include "order_book_level_table_assert.svh"

module obl_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [obl_pkg::VAL_W-1:0]  out_price,
  input logic [obl_pkg::VAL_W-1:0]  out_volume,
  input logic [obl_pkg::ST_W-1:0]   out_status,
  input logic                       out_price_ok,
  input logic [obl_pkg::CNT_W-1:0]  out_level_count
);
  import obl_pkg::*;

  `OBL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `OBL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `OBL_ASSERT_NOW(a_full_count, out_valid && out_status == ST_FULL, out_level_count == CNT_MAX)
  `OBL_ASSERT_NOW(a_ok_clean, out_valid && out_price_ok, out_status == ST_OK && out_price == '0 && out_volume == '0)

endmodule

bind order_book_level_table obl_checker u_obl_checker (.*);

[verif/tb.sv]
`timescale 1ns / 100ps
// Testbench for order_book_level_table: directed and random requests, a scoreboard
// that tracks both price level tables, and price band writes between phases.
// Depends on obl_pkg and the order_book_level_table RTL.
module tb;
  import obl_pkg::*;

  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int STUCK_LIMIT     = 5000;
  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              side;
    logic [LVL_W-1:0]  level;
    logic [VAL_W-1:0]  price;
    logic [VAL_W-1:0]  volume;
  } book_request_t;

  typedef struct packed {
    logic [VAL_W-1:0] price;
    logic [VAL_W-1:0] volume;
    logic [ST_W-1:0]  status;
    logic             price_ok;
    logic [CNT_W-1:0] level_count;
  } book_result_t;

  class level_book_scoreboard;
    entry_t           book[2][MAX_LEVELS];
    int unsigned      depth[2];
    logic [VAL_W-1:0] band_center;
    book_result_t     pending_results[$];
    int errors, checked, requests, drops, range_hits, in_band;

    function new();
      foreach (book[s, i]) book[s][i] = '0;
      depth[0]    = 32'(CNT_INIT);
      depth[1]    = 32'(CNT_INIT);
      band_center = INIT_PRICE_RST;
    endfunction

    task report_mismatch(string field, longint unsigned got, longint unsigned want);
      if (errors < 40)
        $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $time, field, got, want);
      errors++;
    endtask

    function book_result_t apply_request(book_request_t rq);
      book_result_t    r;
      int unsigned     n, top, i, s, lv;
      longint unsigned scaled, lo, hi;
      r  = '0;
      s  = 32'(rq.side);
      lv = 32'(rq.level);
      n  = depth[s];
      case (rq.func)
        FN_UPDATE: begin
          if (lv < n) begin
            book[s][lv] = {rq.price, rq.volume};
          end else if (n < MAX_LEVELS) begin
            book[s][n] = {rq.price, rq.volume};
            n++;
          end else begin
            r.status = ST_FULL;
          end
        end
        FN_INSERT: begin
          if (lv > n || lv >= MAX_LEVELS) begin
            r.status = ST_RANGE;
          end else begin
            top = n;
            if (n == MAX_LEVELS) begin
              top      = MAX_LEVELS - 1;
              r.status = ST_FULL;
            end else begin
              n++;
            end
            for (i = top; i > lv; i--) book[s][i] = book[s][i-1];
            book[s][lv] = {rq.price, rq.volume};
          end
        end
        FN_DELETE: begin
          if (lv >= n) begin
            r.status = ST_RANGE;
          end else begin
            for (i = lv; i + 1 < n; i++) book[s][i] = book[s][i+1];
            book[s][n-1] = '0;
            n--;
          end
        end
        FN_READ: begin
          if (lv < n) begin
            r.price  = book[s][lv].price;
            r.volume = book[s][lv].volume;
          end else begin
            r.status = ST_RANGE;
          end
        end
        FN_CHECK: begin
          scaled     = 64'(rq.price) * 10;
          lo         = 64'(band_center) * 7;
          hi         = 64'(band_center) * 13;
          r.price_ok = (scaled >= lo) && (scaled <= hi);
        end
        default: ;
      endcase
      depth[s]      = n;
      r.level_count = CNT_W'(n);
      if (r.status == ST_FULL) drops++;
      if (r.status == ST_RANGE) range_hits++;
      if (r.price_ok) in_band++;
      return r;
    endfunction

    function void note_request(book_request_t rq);
      requests++;
      pending_results.insert(pending_results.size(), apply_request(rq));
    endfunction

    task check_result(book_result_t got);
      book_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", 64'(got.level_count), 64'(0));
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (got.price !== want.price)
          report_mismatch("out_price", 64'(got.price), 64'(want.price));
        if (got.volume !== want.volume)
          report_mismatch("out_volume", 64'(got.volume), 64'(want.volume));
        if (got.status !== want.status)
          report_mismatch("out_status", 64'(got.status), 64'(want.status));
        if (got.price_ok !== want.price_ok)
          report_mismatch("out_price_ok", 64'(got.price_ok), 64'(want.price_ok));
        if (got.level_count !== want.level_count)
          report_mismatch("out_level_count", 64'(got.level_count),
                          64'(want.level_count));
      end
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [FUNC_W-1:0] in_func;
  logic              in_side;
  logic [LVL_W-1:0]  in_level;
  logic [VAL_W-1:0]  in_price;
  logic [VAL_W-1:0]  in_volume;
  logic              out_valid;
  logic              out_stall;
  logic [VAL_W-1:0]  out_price;
  logic [VAL_W-1:0]  out_volume;
  logic [ST_W-1:0]   out_status;
  logic              out_price_ok;
  logic [CNT_W-1:0]  out_level_count;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  level_book_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int band_writes;

  order_book_level_table dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_side        (in_side),
    .in_level       (in_level),
    .in_price       (in_price),
    .in_volume      (in_volume),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_price      (out_price),
    .out_volume     (out_volume),
    .out_status     (out_status),
    .out_price_ok   (out_price_ok),
    .out_level_count(out_level_count),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_request('{in_func, in_side, in_level, in_price, in_volume});
      if (out_valid && !out_stall)
        sb.check_result('{out_price, out_volume, out_status, out_price_ok, out_level_count});
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transaction for %0d cycles", STUCK_LIMIT);
    $display("Verification failed");
    $finish;
  end

  task automatic send_request(book_request_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= rq.func;
    in_side   <= rq.side;
    in_level  <= rq.level;
    in_price  <= rq.price;
    in_volume <= rq.volume;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_band_center(logic [VAL_W-1:0] center);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_INIT_PRICE, 2'b00};
    pwdata  <= {1'($urandom_range(1)), center};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.band_center = center;
    band_writes++;
  endtask

  function automatic logic [VAL_W-1:0] random_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return VAL_MAX;
      default: return VAL_W'($urandom());
    endcase
  endfunction

  // bias: 0 drains the tables, 1 keeps them balanced, 2 fills them
  function automatic book_request_t random_request(int bias);
    book_request_t   rq;
    int unsigned     n, pick, ins_w, del_w;
    longint unsigned lo_edge, hi_edge, probe;
    rq.side   = 1'($urandom_range(1));
    n         = sb.depth[rq.side];
    ins_w     = (bias == 2) ? 40 : (bias == 1) ? 25 : 10;
    del_w     = (bias == 2) ? 8 : (bias == 1) ? 20 : 40;
    pick      = $urandom_range(99);
    if (pick < ins_w) rq.func = FN_INSERT;
    else if (pick < ins_w + del_w) rq.func = FN_DELETE;
    else if (pick < ins_w + del_w + 20) rq.func = FN_UPDATE;
    else if (pick < ins_w + del_w + 35) rq.func = FN_READ;
    else if (pick < ins_w + del_w + 50) rq.func = FN_CHECK;
    else rq.func = FUNC_W'($urandom_range(7, 5));
    if ($urandom_range(9) < 8) rq.level = LVL_W'($urandom_range((n > 15) ? 15 : n));
    else rq.level = LVL_W'($urandom());
    rq.price  = random_value();
    rq.volume = random_value();
    if (rq.func == FN_CHECK) begin
      lo_edge = (64'(sb.band_center) * 7 + 9) / 10;
      hi_edge = 64'(sb.band_center) * 13 / 10;
      case ($urandom_range(5))
        0:       probe = lo_edge;
        1:       probe = (lo_edge == 0) ? 64'(0) : lo_edge - 1;
        2:       probe = hi_edge;
        3:       probe = hi_edge + 1;
        4:       probe = 64'(sb.band_center);
        default: probe = 64'(rq.price);
      endcase
      if (probe > 64'(VAL_MAX)) probe = 64'(VAL_MAX);
      rq.price = probe[VAL_W-1:0];
    end
    return rq;
  endfunction

  initial begin
    int unsigned      i, f;
    int               sender_mode[PHASES];
    int               stall_mode[PHASES];
    int               bias_mode[PHASES];
    logic [VAL_W-1:0] center;

    sender_mode    = '{0, 80, 0, 20, 0, 20};
    stall_mode     = '{0, 0, 80, 20, 0, 80};
    bias_mode      = '{2, 0, 1, 2, 0, 1};
    sb             = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    band_writes    = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = '0;
    in_side        = 1'b0;
    in_level       = '0;
    in_price       = '0;
    in_volume      = '0;
    out_stall      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: band center at its reset value, both tables at the initial depth
    send_request('{FN_READ, 1'b0, 4'd0, '0, '0});
    send_request('{FN_READ, 1'b0, 4'd10, '0, '0});
    send_request('{FN_UPDATE, 1'b0, 4'd3, VAL_MAX, VAL_MAX});
    send_request('{FN_UPDATE, 1'b0, 4'd12, 31'd5, 31'd6});
    send_request('{FN_INSERT, 1'b0, 4'd0, '0, VAL_MAX});
    send_request('{FN_INSERT, 1'b0, 4'd13, 31'd9, 31'd9});
    send_request('{FN_INSERT, 1'b0, 4'd12, 31'd7, 31'd8});
    send_request('{FN_DELETE, 1'b0, 4'd0, '0, '0});
    send_request('{FN_DELETE, 1'b0, 4'd12, '0, '0});
    send_request('{FN_READ, 1'b0, 4'd3, '0, '0});
    send_request('{FN_CHECK, 1'b0, 4'd0, '0, '0});
    send_request('{FN_CHECK, 1'b1, 4'd0, 31'd1, '0});
    send_request('{FN_CHECK, 1'b0, 4'd0, VAL_MAX, '0});
    for (f = FN_CHECK + 1; f < (1 << FUNC_W); f++)
      send_request('{FUNC_W'(f), 1'($urandom_range(1)), 4'd2, VAL_MAX, VAL_MAX});
    for (i = 0; i < 6; i++)
      send_request('{FN_INSERT, 1'b1, LVL_W'(i), VAL_W'(100 + i), VAL_W'(i)});
    send_request('{FN_INSERT, 1'b1, 4'd15, 31'd77, 31'd88});
    send_request('{FN_INSERT, 1'b1, 4'd0, 31'd55, 31'd66});
    send_request('{FN_READ, 1'b1, 4'd15, '0, '0});
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       center = '0;
        1:       center = VAL_MAX;
        3:       center = 31'd1000;
        4:       center = VAL_W'($urandom_range(100, 1));
        5:       center = 31'd1;
        default: center = VAL_W'($urandom());
      endcase
      write_band_center(center);
      send_idle_pct  = sender_mode[p];
      recv_stall_pct = stall_mode[p];
      for (i = 0; i < ITEMS_PER_PHASE; i++) send_request(random_request(bias_mode[p]));
      drain_results();
      recv_stall_pct = 0;
    end

    $display("Checked %0d results for %0d requests across %0d price band settings.",
             sb.checked, sb.requests, band_writes);
    $display("Seen: %0d full-table drops, %0d out-of-range levels, %0d in-band checks.",
             sb.drops, sb.range_hits, sb.in_band);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
